[rtl/top_k_record_selector_top_assert.svh]
// Assertion macros for the top-k record selector.
// Included by top_k_record_selector_top, which carries the concurrent checks; no other dependencies.
`ifndef TOP_K_RECORD_SELECTOR_TOP_ASSERT_SVH
`define TOP_K_RECORD_SELECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TKRS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TKRS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TKRS_ASSERT(label, clk, rstn, prop, msg)
`define TKRS_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

[rtl/tkrs_pkg.sv]
// Shared types, codes and helpers for the top-k record selector.
// No dependencies; imported by tkrs_cell and top_k_record_selector_top.
package tkrs_pkg;

    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic REG_RANK_BY_EDGES = 1'b0;
    localparam logic REG_KEEP_COUNT    = 1'b1;

    localparam logic [4:0] KEEP_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [63:0] id;
        logic [31:0] members;
        logic [31:0] edges;
        logic [31:0] length;
    } entry_t;

    typedef struct packed {
        logic   vld;
        entry_t entry;
    } token_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_APPEND,
        OP_REMOVE,
        OP_REPLACE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic pick_max;   // 1: scan finds largest key (earliest on ties)
        logic edge_key;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SCAN,
        ST_EVICT,
        ST_EMIT,
        ST_OUT
    } state_t;

    function automatic logic [31:0] key_of(entry_t e, logic use_edges);
        return use_edges ? e.edges : e.members;
    endfunction

endpackage

[rtl/tkrs_cell.sv]
// One slot of the record chain: holds a kept entry and one stage of the scan token.
// Depends on tkrs_pkg.
module tkrs_cell #(
    parameter int DEPTH    = 16,
    parameter int CELL_IDX = 0,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tkrs_pkg::cell_ctl_t ctl,
    input  logic [IW-1:0]      pos,
    input  logic [CW-1:0]      total,
    input  tkrs_pkg::entry_t   new_entry,
    input  tkrs_pkg::entry_t   nbr_entry,
    input  tkrs_pkg::token_t   tok_in,
    input  logic [IW-1:0]      tok_idx_in,
    output tkrs_pkg::token_t   tok_out,
    output logic [IW-1:0]      tok_idx_out,
    output tkrs_pkg::entry_t   entry_out
);
    import tkrs_pkg::*;

    entry_t        entry_reg, entry_next;
    token_t        tok_reg, tok_next;
    logic [IW-1:0] tok_idx_reg, tok_idx_next;

    logic [31:0] own_key, in_key;
    logic        occupied, take_own, shift_in, last_slot, append_slot;

    assign own_key     = key_of(entry_reg, ctl.edge_key);
    assign in_key      = key_of(tok_in.entry, ctl.edge_key);
    assign occupied    = CW'(CELL_IDX) < total;
    assign shift_in    = (IW'(CELL_IDX) >= pos) && (CW'(CELL_IDX + 1) < total);
    assign last_slot   = CW'(CELL_IDX + 1) == total;
    assign append_slot = CW'(CELL_IDX) == total;

    // min scan: later slot wins ties; max scan: earlier slot wins ties
    always_comb begin
        take_own = occupied && (!tok_in.vld ||
                   (ctl.pick_max ? (own_key > in_key) : (own_key <= in_key)));
        if (take_own) begin
            tok_next     = '{vld: 1'b1, entry: entry_reg};
            tok_idx_next = IW'(CELL_IDX);
        end else begin
            tok_next     = tok_in;
            tok_idx_next = tok_idx_in;
        end
    end

    always_comb begin
        entry_next = entry_reg;
        unique case (ctl.op)
            OP_NONE: ;
            OP_APPEND: begin
                if (append_slot) entry_next = new_entry;
            end
            OP_REMOVE: begin
                if (shift_in) entry_next = nbr_entry;
            end
            OP_REPLACE: begin
                if (shift_in) entry_next = nbr_entry;
                else if (last_slot) entry_next = new_entry;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg   <= entry_next;
        tok_idx_reg <= tok_idx_next;
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else begin
            tok_reg.vld <= tok_next.vld;
        end
        tok_reg.entry <= tok_next.entry;
    end

    assign tok_out     = tok_reg;
    assign tok_idx_out = tok_idx_reg;
    assign entry_out   = entry_reg;

endmodule

[rtl/top_k_record_selector_top.sv]
// Top-k record selector: controller plus a chain of TABLE_DEPTH record cells.
// Offer: appended directly to a table below its limit; a scan for the smallest entry
// runs first when one is needed. Flush: each result takes a scan through the cell chain,
// an unload of the entry, plus the output beat; an empty flush answers the next cycle.
// One item at a time. Reset (aresetn, sync, active low) empties the table and restores
// rank_by_edges = 0, keep_count = 16; stored entries are kept.
module top_k_record_selector_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [63:0] s_record_id,
    input  logic [31:0] s_member_count,
    input  logic [31:0] s_edge_count,
    input  logic [31:0] s_sequence_length,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_id,
    output logic [31:0] m_out_members,
    output logic [31:0] m_out_edges,
    output logic [31:0] m_out_length,
    output logic        m_is_empty,
    output logic        m_is_last
);
    import tkrs_pkg::*;

    `include "top_k_record_selector_top_assert.svh"

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    state_t        state_reg, state_next;
    logic [CW-1:0] total_reg, total_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          flush_reg, flush_next;
    entry_t        rec_reg, rec_next;
    logic          rank_reg;
    logic [4:0]    keep_reg;
    logic          m_valid_reg, m_valid_next;
    entry_t        out_reg, out_next;
    logic          empty_reg, empty_next;
    logic          last_reg, last_next;

    cell_ctl_t     ctl;
    logic [IW-1:0] pos;

    token_t        tok_chain [TABLE_DEPTH+1];
    logic [IW-1:0] idx_chain [TABLE_DEPTH+1];
    entry_t        ent_chain [TABLE_DEPTH+1];

    logic   below_limit;
    token_t scan_tok;

    assign tok_chain[0] = '0;
    assign idx_chain[0] = '0;
    assign ent_chain[TABLE_DEPTH] = '0;
    assign scan_tok = tok_chain[TABLE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            tkrs_cell #(
                .DEPTH    (TABLE_DEPTH),
                .CELL_IDX (gi)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .pos         (pos),
                .total       (total_reg),
                .new_entry   (rec_reg),
                .nbr_entry   (ent_chain[gi+1]),
                .tok_in      (tok_chain[gi]),
                .tok_idx_in  (idx_chain[gi]),
                .tok_out     (tok_chain[gi+1]),
                .tok_idx_out (idx_chain[gi+1]),
                .entry_out   (ent_chain[gi])
            );
        end
    endgenerate

    // limit is min(keep_count, depth)
    assign below_limit = (LW'(total_reg) < LW'(keep_reg)) &&
                         (total_reg < CW'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= 1'b0;
            keep_reg <= KEEP_COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RANK_BY_EDGES: rank_reg <= cfg_data[0];
                REG_KEEP_COUNT:    keep_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            cnt_reg     <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            cnt_reg     <= cnt_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
        rec_reg   <= rec_next;
        out_reg   <= out_next;
        empty_reg <= empty_next;
        last_reg  <= last_next;
    end

    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        flush_next   = flush_reg;
        rec_next     = rec_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        empty_next   = empty_reg;
        last_next    = last_reg;
        ctl.op       = OP_NONE;
        ctl.pick_max = flush_reg;
        ctl.edge_key = rank_reg;
        pos          = idx_chain[TABLE_DEPTH];
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    rec_next = '{id: s_record_id, members: s_member_count,
                                 edges: s_edge_count, length: s_sequence_length};
                    cnt_next = '0;
                    if (s_kind == KIND_FLUSH) begin
                        flush_next = 1'b1;
                        if (total_reg == '0) begin
                            out_next     = '0;
                            empty_next   = 1'b1;
                            last_next    = 1'b1;
                            m_valid_next = 1'b1;
                            state_next   = ST_OUT;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else begin
                        flush_next = 1'b0;
                        if (below_limit) state_next = ST_APPEND;
                        else if (total_reg != '0) state_next = ST_SCAN;
                    end
                end
            end
            ST_APPEND: begin
                ctl.op     = OP_APPEND;
                total_next = total_reg + CW'(1);
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                // token passes through every cell's register before it settles at the chain's end
                if (cnt_reg == IW'(TABLE_DEPTH - 1)) begin
                    state_next = flush_reg ? ST_EMIT : ST_EVICT;
                end else begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_EVICT: begin
                if (scan_tok.vld &&
                    (key_of(rec_reg, rank_reg) > key_of(scan_tok.entry, rank_reg))) begin
                    ctl.op = OP_REPLACE;
                end
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                ctl.op       = OP_REMOVE;
                out_next     = scan_tok.entry;
                empty_next   = 1'b0;
                last_next    = total_reg == CW'(1);
                m_valid_next = 1'b1;
                total_next   = total_reg - CW'(1);
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = (total_reg == '0) ? ST_IDLE : ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_out_id      = out_reg.id;
    assign m_out_members = out_reg.members;
    assign m_out_edges   = out_reg.edges;
    assign m_out_length  = out_reg.length;
    assign m_is_empty    = empty_reg;
    assign m_is_last     = last_reg;

    `TKRS_ASSERT(a_total_bound, aclk, aresetn, total_reg <= CW'(TABLE_DEPTH), "kept count over depth")
    `TKRS_ASSERT(a_no_overlap, aclk, aresetn, !(s_ready && m_valid), "input taken while result pending")
    `TKRS_ASSERT(a_last_empties, aclk, aresetn, (m_valid && m_ready && m_is_last) |=> (total_reg == '0), "table not empty after last beat")
    `TKRS_ASSERT(a_more_rescans, aclk, aresetn, (m_valid && m_ready && !m_is_last) |=> (state_reg == ST_SCAN), "no rescan after non-last beat")
    `TKRS_ASSERT(a_evict_nonempty, aclk, aresetn, (state_reg == ST_EVICT) |-> (total_reg != '0), "eviction on empty table")
    `TKRS_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> (!m_valid && (state_reg == ST_IDLE)), "reset did not idle block")

endmodule

[tb/tb_top_k_record_selector_top.sv]
// Self-checking bench for top_k_record_selector_top: directed and random record streams,
// a queue-based predictor of the kept table, and a scoreboard on the flush beats.
// Depends on tkrs_pkg and the RTL of top_k_record_selector_top.
`timescale 1ns / 1ps

module tb_top_k_record_selector_top;
    import tkrs_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DRAIN_WAIT  = 40;    // waits out the longest offer, which scans the cell chain
    localparam int STALL_LIMIT = 4000;  // cycles with no beat on either channel
    localparam int HOLD_CYCLES = 500;

    typedef struct packed {
        logic   kind;
        entry_t rec;
    } record_beat_t;

    typedef struct packed {
        logic [63:0] id;
        logic [31:0] members;
        logic [31:0] edges;
        logic [31:0] length;
        logic        is_empty;
        logic        is_last;
    } flush_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_RANK_BY_EDGES;
    logic [4:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = KIND_OFFER;
    logic [63:0] s_record_id = '0;
    logic [31:0] s_member_count = '0;
    logic [31:0] s_edge_count = '0;
    logic [31:0] s_sequence_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_out_id;
    logic [31:0] m_out_members;
    logic [31:0] m_out_edges;
    logic [31:0] m_out_length;
    logic        m_is_empty;
    logic        m_is_last;

    top_k_record_selector_top #(.TABLE_DEPTH(DEPTH)) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_record_id       (s_record_id),
        .s_member_count    (s_member_count),
        .s_edge_count      (s_edge_count),
        .s_sequence_length (s_sequence_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_id          (m_out_id),
        .m_out_members     (m_out_members),
        .m_out_edges       (m_out_edges),
        .m_out_length      (m_out_length),
        .m_is_empty        (m_is_empty),
        .m_is_last         (m_is_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    record_beat_t record_q[$];     // beats waiting to be driven
    record_beat_t live_beat;       // beat currently on the input channel
    flush_beat_t  ranked_q[$];     // flush beats the table should produce
    flush_beat_t  got_beat;
    entry_t       kept_q[$];       // predicted table, arrival order
    logic         rank_edges = 1'b0;
    logic [4:0]   keep_lim = KEEP_COUNT_RESET;
    bit           no_idle = 1'b0;
    bit           hold_req = 1'b0;
    bit           hold_taken = 1'b0;
    int           hold_left = 0;
    int           fail_cnt = 0;
    int           stall_cycles = 0;

    function automatic logic [31:0] rank_key(entry_t e);
        return rank_edges ? e.edges : e.members;
    endfunction

    function automatic void select_offer(entry_t e);
        int unsigned limit;
        int          victim;
        limit = (keep_lim > DEPTH) ? DEPTH : keep_lim;
        if (kept_q.size() < limit) begin
            kept_q.insert(kept_q.size(), e);
            return;
        end
        if (kept_q.size() == 0)
            return;
        // smallest key, latest arrival on ties
        victim = 0;
        for (int i = 1; i < kept_q.size(); i++)
            if (rank_key(kept_q[i]) <= rank_key(kept_q[victim]))
                victim = i;
        if (rank_key(e) <= rank_key(kept_q[victim]))
            return;
        kept_q.delete(victim);
        kept_q.insert(kept_q.size(), e);
    endfunction

    function automatic void rank_and_flush();
        flush_beat_t b;
        int          best;
        b = '0;
        if (kept_q.size() == 0) begin
            b.is_empty = 1'b1;
            b.is_last  = 1'b1;
            ranked_q.insert(ranked_q.size(), b);
            return;
        end
        // largest key first, earliest arrival on ties
        while (kept_q.size() != 0) begin
            best = 0;
            for (int i = 1; i < kept_q.size(); i++)
                if (rank_key(kept_q[i]) > rank_key(kept_q[best]))
                    best = i;
            b.id       = kept_q[best].id;
            b.members  = kept_q[best].members;
            b.edges    = kept_q[best].edges;
            b.length   = kept_q[best].length;
            b.is_empty = 1'b0;
            b.is_last  = (kept_q.size() == 1);
            ranked_q.insert(ranked_q.size(), b);
            kept_q.delete(best);
        end
    endfunction

    // Driver: next beat from record_q, random gaps unless no_idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                if (live_beat.kind == KIND_FLUSH)
                    rank_and_flush();
                else
                    select_offer(live_beat.rec);
            end
            if (record_q.size() != 0 && (no_idle || $urandom_range(99) >= 36)) begin
                live_beat = record_q.pop_front();
                s_valid           <= 1'b1;
                s_kind            <= live_beat.kind;
                s_record_id       <= live_beat.rec.id;
                s_member_count    <= live_beat.rec.members;
                s_edge_count      <= live_beat.rec.edges;
                s_sequence_length <= live_beat.rec.length;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Monitor: checks result beats, drives m_ready with random and long stalls.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (ranked_q.size() == 0) begin
                $error("result beat with nothing expected: id %0h", m_out_id);
                fail_cnt++;
            end else begin
                got_beat = ranked_q.pop_front();
                check_field("out_id", got_beat.id, m_out_id);
                check_field("out_members", 64'(got_beat.members), 64'(m_out_members));
                check_field("out_edges", 64'(got_beat.edges), 64'(m_out_edges));
                check_field("out_length", 64'(got_beat.length), 64'(m_out_length));
                check_field("is_empty", 64'(got_beat.is_empty), 64'(m_is_empty));
                check_field("is_last", 64'(got_beat.is_last), 64'(m_is_last));
            end
        end
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("top_k_record_selector_top regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_offer(logic [63:0] id, logic [31:0] mem, logic [31:0] edg,
                              logic [31:0] len);
        record_beat_t b;
        b.kind        = KIND_OFFER;
        b.rec.id      = id;
        b.rec.members = mem;
        b.rec.edges   = edg;
        b.rec.length  = len;
        record_q.insert(record_q.size(), b);
    endtask

    task automatic push_flush();
        record_beat_t b;
        b.kind        = KIND_FLUSH;
        b.rec.id      = {$urandom, $urandom};
        b.rec.members = $urandom;
        b.rec.edges   = $urandom;
        b.rec.length  = $urandom;
        record_q.insert(record_q.size(), b);
    endtask

    // Small keys most of the time so ties and evictions are frequent.
    function automatic logic [31:0] rand_key();
        case ($urandom_range(9))
            6, 7:    return $urandom;
            8:       return 32'h0;
            9:       return 32'hFFFF_FFFF;
            default: return $urandom_range(12);
        endcase
    endfunction

    task automatic push_random_offer();
        push_offer({$urandom, $urandom}, rand_key(), rand_key(), $urandom);
    endtask

    // Block is idle once both queues are empty and the last offer has settled.
    task automatic wait_idle();
        while (record_q.size() != 0 || s_valid || ranked_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_RANK_BY_EDGES)
            rank_edges = val[0];
        else
            keep_lim = val;
    endtask

    initial begin
        int random_sent;
        int phase;
        int n;
        logic [4:0] lim;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: empty flush, field extremes, member-count ties
        push_flush();
        push_offer(64'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
        push_offer(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        push_offer(64'h0123_4567_89AB_CDEF, 32'h0, 32'h5, 32'h1234);
        push_flush();
        wait_idle();

        // two kept by edges: equal smallest keys evict the later one, equal key is refused
        write_reg(REG_RANK_BY_EDGES, 5'd1);
        write_reg(REG_KEEP_COUNT, 5'd2);
        push_offer(64'hA, 32'd1, 32'd5, 32'd100);
        push_offer(64'hB, 32'd9, 32'd5, 32'd101);
        push_offer(64'hC, 32'd2, 32'd7, 32'd102);
        push_offer(64'hD, 32'd8, 32'd5, 32'd103);
        push_flush();
        wait_idle();

        // limit of zero keeps nothing
        write_reg(REG_KEEP_COUNT, 5'd0);
        push_offer(64'hE, 32'd3, 32'd3, 32'd3);
        push_offer(64'hF, 32'd4, 32'd4, 32'd4);
        push_flush();
        wait_idle();

        // limit lowered with entries kept, then ranking mode switched before flush
        write_reg(REG_RANK_BY_EDGES, 5'd0);
        write_reg(REG_KEEP_COUNT, 5'd16);
        push_offer(64'h10, 32'd10, 32'd40, 32'd1);
        push_offer(64'h11, 32'd20, 32'd30, 32'd2);
        push_offer(64'h12, 32'd30, 32'd20, 32'd3);
        push_offer(64'h13, 32'd40, 32'd10, 32'd4);
        wait_idle();
        write_reg(REG_KEEP_COUNT, 5'd2);
        push_offer(64'h14, 32'd25, 32'd25, 32'd5);
        wait_idle();
        write_reg(REG_RANK_BY_EDGES, 5'd1);
        push_offer(64'h15, 32'd1, 32'd50, 32'd6);
        push_flush();
        wait_idle();

        // limit of one
        write_reg(REG_KEEP_COUNT, 5'd1);
        push_offer(64'h16, 32'd7, 32'd7, 32'd7);
        push_offer(64'h17, 32'd8, 32'd6, 32'd8);
        push_flush();
        wait_idle();

        random_sent = 0;
        phase = 0;
        while (random_sent < 215) begin
            // upper data bits of the mode register are don't-care
            write_reg(REG_RANK_BY_EDGES, {4'($urandom_range(15)), 1'($urandom_range(1))});
            case ($urandom_range(7))
                0:       lim = 5'd0;
                1:       lim = 5'd1;
                2:       lim = 5'd16;
                3:       lim = 5'($urandom_range(17, 31));
                4:       lim = 5'd31;
                default: lim = 5'($urandom_range(2, 15));
            endcase
            if (phase == 0)
                lim = 5'd16;
            write_reg(REG_KEEP_COUNT, lim);
            no_idle = (phase == 2);
            if (phase == 0) begin
                // long receiver stall while the table fills and a flush backs up
                hold_req = 1'b1;
                for (int i = 0; i < 16; i++)
                    push_random_offer();
                push_flush();
                for (int i = 0; i < 20; i++)
                    push_random_offer();
                push_flush();
                random_sent += 38;
            end else begin
                // the gap-free phase always gets a long run
                n = (phase == 2) ? 40 : $urandom_range(5, 40);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(7) == 0)
                        push_flush();
                    else
                        push_random_offer();
                end
                random_sent += n;
            end
            wait_idle();
            no_idle = 1'b0;
            phase++;
        end

        push_flush();
        wait_idle();
        if (fail_cnt == 0 && ranked_q.size() == 0) begin
            $display("top_k_record_selector_top regression: pass");
        end else begin
            $display("top_k_record_selector_top regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tkrs_pkg.sv
rtl/tkrs_cell.sv
rtl/top_k_record_selector_top.sv
tb/tb_top_k_record_selector_top.sv
